[rtl/dcs_pkg.sv]
// Package for the descending counting sort core: field widths, mode and
// status codes, and the sequencer state type. No dependencies.
package dcs_pkg;

  localparam int KEY_W  = 12;
  localparam int LEN_W  = 16;
  localparam int BIN_W  = 17;
  localparam int SLOT_W = 16;

  typedef enum logic [1:0] {
    MODE_COUNT  = 2'd0,
    MODE_FINISH = 2'd1,
    MODE_PLACE  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SUM   = 2'd1,
    ST_DRAIN = 2'd2,
    ST_CLEAR = 2'd3
  } state_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_KEY = 1'b1;

endpackage

[rtl/descending_counting_sort_core.sv]
// Descending counting sort core: histogram memory, read-modify-write path
// with forwarding, suffix-sum walk and clearing pass. Depends on dcs_pkg.
//
// Channel   Direction  Handshake            Payload
// command   in         start && !busy       mode, key, line_length
// result    out        done (one cycle)     status, slot, key_out, record_offset
//
// Count and place words may follow back to back; the result appears on the
// cycle after acceptance, once the registered histogram memory read returns.
// A finish word holds busy while the bins are walked from the top, one memory
// entry per cycle. A clear word and reset each hold busy through a clearing
// pass, one entry per cycle. Reset is synchronous; the receiver cannot stall
// results.
module descending_counting_sort_core
  import dcs_pkg::*;
#(
  parameter int KEY_DEPTH   = 4096,
  parameter int OFFSET_BITS = 40
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             mode,
  input  logic [KEY_W-1:0]       key,
  input  logic [LEN_W-1:0]       line_length,
  output logic                   done,
  output logic                   status,
  output logic [SLOT_W-1:0]      slot,
  output logic [KEY_W-1:0]       key_out,
  output logic [OFFSET_BITS-1:0] record_offset
);

  localparam int AW = $clog2(KEY_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(KEY_DEPTH - 1);
  localparam logic [AW-1:0] ONE_ADDR  = AW'(1);

  // histogram memory
  logic [BIN_W-1:0] mem [KEY_DEPTH];
  logic [BIN_W-1:0] rd_data;
  logic [AW-1:0]    rd_addr;
  logic             we;
  logic [AW-1:0]    wa;
  logic [BIN_W-1:0] wd;

  state_t state, state_next;
  logic [AW-1:0] ptr;
  logic          accept;
  mode_t         in_mode;
  logic          in_usable;
  logic [AW-1:0] in_addr;

  logic [OFFSET_BITS-1:0] offset;

  // item stage one
  logic                   s1_valid;
  mode_t                  s1_mode;
  logic [KEY_W-1:0]       s1_key;
  logic                   s1_usable;
  logic [AW-1:0]          s1_addr;
  logic [OFFSET_BITS-1:0] s1_offset;

  // forwarding of the last item write
  logic             fwd_valid;
  logic [AW-1:0]    fwd_addr;
  logic [BIN_W-1:0] fwd_data;

  // suffix-sum walk
  logic             sum_pend;
  logic [AW-1:0]    sum_addr;
  logic [BIN_W-1:0] acc;
  logic             sum_first;
  logic [BIN_W-1:0] sum_val;
  logic             sum_rd;

  logic             clr_we;
  logic [BIN_W-1:0] bin_cur;
  logic [BIN_W-1:0] bin_new;
  logic             item_we;

  assign in_mode   = mode_t'(mode);
  assign accept    = start && !busy;
  assign in_usable = (key != '0) && (32'(key) < KEY_DEPTH);
  assign in_addr   = AW'(32'(key));

  // next state of the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_mode == MODE_FINISH) begin
          state_next = ST_SUM;
        end else if (accept && in_mode == MODE_CLEAR) begin
          state_next = ST_CLEAR;
        end
      end
      ST_SUM: begin
        if (ptr == ONE_ADDR) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_IDLE;
      ST_CLEAR: begin
        if (ptr == LAST_ADDR) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy    = 1'b1;
    sum_rd  = 1'b0;
    clr_we  = 1'b0;
    rd_addr = in_addr;
    unique case (state)
      ST_IDLE:  busy = 1'b0;
      ST_SUM: begin
        sum_rd  = 1'b1;
        rd_addr = ptr;
      end
      ST_DRAIN: busy = 1'b1;
      ST_CLEAR: clr_we = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  // hold state and walk pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      ptr   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && accept && in_mode == MODE_FINISH) begin
        ptr <= LAST_ADDR;
      end else if (state == ST_IDLE && accept && in_mode == MODE_CLEAR) begin
        ptr <= '0;
      end else if (state == ST_SUM) begin
        ptr <= ptr - ONE_ADDR;
      end else if (state == ST_CLEAR) begin
        ptr <= ptr + ONE_ADDR;
      end
    end
  end

  // advance the running byte offset on place words, zero it on clear words
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (accept && in_mode == MODE_PLACE) begin
      offset <= offset + OFFSET_BITS'(line_length);
    end else if (accept && in_mode == MODE_CLEAR) begin
      offset <= '0;
    end
  end

  // capture the accepted word into stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_mode   <= in_mode;
      s1_key    <= key;
      s1_usable <= in_usable;
      s1_addr   <= in_addr;
      s1_offset <= offset;
    end
  end

  // modify the bin, taking the previous write when it hit the same entry
  always_comb begin
    bin_cur = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rd_data;
    bin_new = (s1_mode == MODE_COUNT) ? bin_cur + BIN_W'(1) : bin_cur - BIN_W'(1);
    item_we = s1_valid && s1_usable &&
              (s1_mode == MODE_COUNT || s1_mode == MODE_PLACE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= item_we;
    end
    fwd_addr <= s1_addr;
    fwd_data <= bin_new;
  end

  // suffix sum: the top bin seeds the total, lower bins add it in
  assign sum_first = (sum_addr == LAST_ADDR);
  assign sum_val   = sum_first ? rd_data : rd_data + acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_pend <= 1'b0;
    end else begin
      sum_pend <= sum_rd;
    end
    sum_addr <= ptr;
    if (sum_pend) acc <= sum_val;
  end

  // select the single write port
  always_comb begin
    we = 1'b0;
    wa = s1_addr;
    wd = bin_new;
    priority if (clr_we) begin
      we = 1'b1;
      wa = ptr;
      wd = '0;
    end else if (sum_pend && !sum_first) begin
      we = 1'b1;
      wa = sum_addr;
      wd = sum_val;
    end else if (item_we) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[rd_addr];
  end

  // drive the result word
  assign done          = s1_valid;
  assign status        = (s1_mode == MODE_COUNT && !s1_usable) ? STATUS_BAD_KEY : STATUS_OK;
  assign slot          = (s1_mode == MODE_PLACE && s1_usable) ? bin_new[SLOT_W-1:0] : '0;
  assign key_out       = s1_key;
  assign record_offset = s1_offset;

endmodule

[rtl/dcs_checker.sv]
// Port-level checker for the descending counting sort core, with its bind.
// Depends on dcs_pkg and descending_counting_sort_core.
module dcs_checker
  import dcs_pkg::*;
#(
  parameter int OFFSET_BITS = 40
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic [1:0]             mode,
  input logic [KEY_W-1:0]       key,
  input logic                   done,
  input logic                   status,
  input logic [SLOT_W-1:0]      slot,
  input logic [KEY_W-1:0]       key_out,
  input logic [OFFSET_BITS-1:0] record_offset
);

  // every accepted word gives its result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("accepted word gave no result");

  // no result without an accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result without accepted word");

  // result echoes the key of the word accepted the cycle before
  a_key_echo: assert property (@(posedge clk) disable iff (rst)
    done |-> key_out == $past(key))
    else $error("key echo mismatch");

  // a rejected key never carries a slot
  a_bad_key_slot: assert property (@(posedge clk) disable iff (rst)
    done && status |-> slot == '0)
    else $error("slot set on rejected key");

  // finish and clear words raise busy for the walk
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (mode == MODE_FINISH || mode == MODE_CLEAR) |=> busy)
    else $error("walk did not raise busy");

endmodule

bind descending_counting_sort_core dcs_checker #(.OFFSET_BITS(OFFSET_BITS)) u_dcs_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .mode          (mode),
  .key           (key),
  .done          (done),
  .status        (status),
  .slot          (slot),
  .key_out       (key_out),
  .record_offset (record_offset)
);
